[src/usbreq_pkg.sv]
`timescale 1ns / 1ps
package usbreq_pkg;

  // Endpoint-zero packet size and the largest packet the engine emits
  localparam int unsigned Ep0PacketBytes = 8;
  localparam int unsigned PktBytes = (Ep0PacketBytes < 8) ? Ep0PacketBytes : 8;
  localparam int unsigned CfgTotal = 32;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ZLP   = 2'd1,
    KIND_STALL = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    LINK_UNINIT  = 2'd0,
    LINK_READY   = 2'd1,
    LINK_BUSY    = 2'd2,
    LINK_SUSPEND = 2'd3
  } link_e;

  typedef enum logic [2:0] {
    OP_SETUP   = 3'd0,
    OP_IN_ACK  = 3'd1,
    OP_RESET   = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESUME  = 3'd4
  } op_e;

  localparam logic [7:0] REQ_GET_STATUS = 8'h00;
  localparam logic [7:0] REQ_CLR_FEAT   = 8'h01;
  localparam logic [7:0] REQ_SET_FEAT   = 8'h03;
  localparam logic [7:0] REQ_SET_ADDR   = 8'h05;
  localparam logic [7:0] REQ_GET_DESC   = 8'h06;
  localparam logic [7:0] REQ_GET_CFG    = 8'h08;
  localparam logic [7:0] REQ_SET_CFG    = 8'h09;
  localparam logic [7:0] REQ_SET_IFACE  = 8'h0B;

  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;
  localparam logic [7:0] DESC_QUAL   = 8'd6;

  // Descriptor sources
  localparam logic [2:0] SRC_SMALL = 3'd0;
  localparam logic [2:0] SRC_DEV   = 3'd1;
  localparam logic [2:0] SRC_CFG   = 3'd2;
  localparam logic [2:0] SRC_LANG  = 3'd3;
  localparam logic [2:0] SRC_STR1  = 3'd4;
  localparam logic [2:0] SRC_STR2  = 3'd5;
  localparam logic [2:0] SRC_QUAL  = 3'd6;

  localparam logic [7:0] PKT8 = 8'(Ep0PacketBytes);

  localparam logic [7:0] DEV_DESC [18] = '{
    8'd18, 8'd1, 8'h00, 8'h02, 8'd2, 8'd0, 8'd0, PKT8,
    8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'd1, 8'd2, 8'd0, 8'd1};
  localparam logic [7:0] CFG_DESC [32] = '{
    8'd9, 8'd2, 8'h20, 8'h00, 8'd1, 8'd1, 8'd0, 8'hC0, 8'd0,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'hFF, 8'hFF, 8'hFF, 8'd0,
    8'd7, 8'd5, 8'h01, 8'h02, 8'd64, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h82, 8'h02, 8'd64, 8'd0, 8'd0};
  localparam logic [7:0] LANG_DESC [4] = '{8'd4, 8'd3, 8'h09, 8'h04};
  localparam logic [7:0] STR1_DESC [12] = '{
    8'd12, 8'd3, 8'h4C, 8'd0, 8'h45, 8'd0, 8'h47, 8'd0, 8'h4F, 8'd0, 8'd0, 8'd0};
  localparam logic [7:0] STR2_DESC [12] = '{
    8'd12, 8'd3, 8'h4E, 8'd0, 8'h78, 8'd0, 8'h4F, 8'd0, 8'h53, 8'd0, 8'd0, 8'd0};
  localparam logic [7:0] QUAL_DESC [10] = '{
    8'd10, 8'd6, 8'h00, 8'h02, 8'd2, 8'd0, 8'd0, PKT8, 8'd1, 8'd0};

  // One descriptor byte; ids patched into the device descriptor
  function automatic logic [7:0] rom_byte(input logic [2:0] src, input logic [5:0] off,
                                          input logic [15:0] vid, input logic [15:0] pid);
    logic [7:0] b;
    b = 8'd0;
    case (src)
      SRC_DEV: begin
        if (off == 6'd8) b = vid[7:0];
        else if (off == 6'd9) b = vid[15:8];
        else if (off == 6'd10) b = pid[7:0];
        else if (off == 6'd11) b = pid[15:8];
        else if (off < 6'd18) b = DEV_DESC[off[4:0]];
      end
      SRC_CFG:  if (off < 6'd32) b = CFG_DESC[off[4:0]];
      SRC_LANG: if (off < 6'd4) b = LANG_DESC[off[1:0]];
      SRC_STR1: if (off < 6'd12) b = STR1_DESC[off[3:0]];
      SRC_STR2: if (off < 6'd12) b = STR2_DESC[off[3:0]];
      SRC_QUAL: if (off < 6'd10) b = QUAL_DESC[off[3:0]];
      default:  b = 8'd0;
    endcase
    return b;
  endfunction

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

endpackage

[src/usb_control_request_responder.sv]
`timescale 1ns / 1ps
// Endpoint-zero standard request engine.
// Input channel (in_valid_i / in_ready_o): one setup packet or bus event per
// transfer. Output channel (out_valid_o / out_ready_i): one result per
// transfer; data bytes of a packet come one per transfer, last_of_packet_o
// marks the final result caused by an input. Every input causes at least one
// result (kind "no packet" when nothing is sent).
// Config channel (cfg_valid_i / cfg_ready_o): index 0 vendor id, 1 product id;
// always ready, write only while no input is in flight.
// Flow: the input is decoded in the cycle it is accepted and the plan and
// state registers take it; the sequencer then fills the output register and
// walks the descriptor ROM one byte per cycle while the receiver does not
// stall, giving at most 8 results (one packet) per input. The input is not ready
// while results of the current item are still being produced.
// Stalls: when the receiver holds out_ready_i low the output register holds
// its result and the sequencer waits.
// Reset: asynchronous, active low; clears address, configuration, link
// status and transfer state and loads the default vendor and product ids.
module usb_control_request_responder
  import usbreq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_index_i,
  input  logic [15:0] request_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_of_packet_o,
  output logic [6:0]  device_address_o,
  output logic        configured_o,
  output logic [7:0]  current_configuration_o,
  output logic [1:0]  link_status_o
);

  localparam logic [3:0] PKT = 4'(PktBytes);

  // Function state
  logic [15:0] vid_q, pid_q;
  logic [1:0]  stat_q, stat_d, stat_sv_q, stat_sv_d;
  logic [6:0]  pend_q, pend_d, addr_q, addr_d;
  logic [7:0]  selcfg_q, selcfg_d;
  logic        cfgd_q, cfgd_d;
  logic [2:0]  src_q, src_d;
  logic [5:0]  off_q, off_d, rem_q, rem_d;
  logic        zpo_q, zpo_d;

  // Emission plan
  state_e      state_q, state_d;
  kind_e       pkind_q, pkind_d;
  logic [3:0]  pcnt_q, pcnt_d;
  logic [2:0]  psrc_q, psrc_d;
  logic [5:0]  poff_q, poff_d;
  logic [7:0]  pb0_q, pb0_d;
  logic [3:0]  k_q, k_d;

  // Output register
  logic        ov_q, ov_d;
  kind_e       okind_q, okind_d;
  logic [7:0]  odata_q, odata_d;
  logic        olast_q, olast_d;
  logic [6:0]  oaddr_q;
  logic        ocfgd_q;
  logic [7:0]  oselcfg_q;
  logic [1:0]  ostat_q;

  logic        in_fire, load;
  logic [5:0]  size, req_rem;
  logic [3:0]  npk;
  logic [7:0]  idx;
  logic [3:0]  total;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign idx         = request_value_i[7:0];

  // Decode the input and update the function state
  always_comb begin
    stat_d = stat_q; stat_sv_d = stat_sv_q; pend_d = pend_q; addr_d = addr_q;
    selcfg_d = selcfg_q; cfgd_d = cfgd_q; src_d = src_q; off_d = off_q;
    rem_d = rem_q; zpo_d = zpo_q;
    pkind_d = KIND_NONE; pcnt_d = 4'd0; psrc_d = SRC_SMALL; poff_d = 6'd0;
    pb0_d = 8'd0;
    size = 6'd0; req_rem = 6'd0; npk = 4'd0;
    unique case (op_i)
      OP_SETUP: begin
        src_d = SRC_SMALL; off_d = 6'd0; rem_d = 6'd0; zpo_d = 1'b0;
        unique case (request_code_i) inside
          REQ_GET_STATUS, REQ_GET_CFG: begin
            if (request_code_i == REQ_GET_STATUS) begin
              size = 6'd2;
              pb0_d = {7'd0, request_type_i[3:0] == 4'd0};
            end else begin
              size = 6'd1;
              pb0_d = selcfg_q;
            end
            req_rem = (request_length_i > 16'(size)) ? size : request_length_i[5:0];
            pcnt_d = req_rem[3:0];
            pkind_d = (req_rem == 6'd0) ? KIND_ZLP : KIND_DATA;
            stat_d = LINK_BUSY;
          end
          REQ_CLR_FEAT, REQ_SET_FEAT, REQ_SET_IFACE: begin
            pkind_d = KIND_ZLP; stat_d = LINK_BUSY;
          end
          REQ_SET_ADDR: begin
            pend_d = request_value_i[6:0];
            pkind_d = KIND_ZLP; stat_d = LINK_BUSY;
            if (request_value_i[6:0] == 7'd0) begin
              addr_d = 7'd0; cfgd_d = 1'b0;
            end
          end
          REQ_SET_CFG: begin
            selcfg_d = idx; cfgd_d = (idx != 8'd0);
            pkind_d = KIND_ZLP; stat_d = LINK_BUSY;
          end
          REQ_GET_DESC: begin
            pkind_d = KIND_STALL;
            unique case (request_value_i[15:8])
              DESC_DEVICE: begin src_d = SRC_DEV; size = 6'd18; end
              DESC_CONFIG: begin
                src_d = SRC_CFG; size = 6'(CfgTotal);
                zpo_d = (request_length_i > 16'(CfgTotal));
              end
              DESC_STRING: begin
                if (idx == 8'd0) begin src_d = SRC_LANG; size = 6'd4; end
                else if (idx == 8'd1) begin src_d = SRC_STR1; size = 6'd12; end
                else if (idx == 8'd2) begin src_d = SRC_STR2; size = 6'd12; end
              end
              DESC_QUAL: begin src_d = SRC_QUAL; size = 6'd10; end
              default: src_d = SRC_SMALL;
            endcase
            if (size != 6'd0) begin
              req_rem = (request_length_i > 16'(size)) ? size : request_length_i[5:0];
              npk = (req_rem > 6'(PKT)) ? PKT : req_rem[3:0];
              pcnt_d = npk; psrc_d = src_d; poff_d = 6'd0;
              pkind_d = (npk == 4'd0) ? KIND_ZLP : KIND_DATA;
              off_d = 6'(npk); rem_d = req_rem - 6'(npk);
              stat_d = LINK_BUSY;
            end
          end
          default: pkind_d = KIND_STALL;
        endcase
      end
      OP_IN_ACK: begin
        stat_d = LINK_READY;
        if (pend_q != 7'd0) begin
          addr_d = pend_q; pend_d = 7'd0; cfgd_d = 1'b0;
        end
        if (rem_q != 6'd0) begin
          npk = (rem_q > 6'(PKT)) ? PKT : rem_q[3:0];
          pcnt_d = npk; psrc_d = src_q; poff_d = off_q; pkind_d = KIND_DATA;
          off_d = off_q + 6'(npk); rem_d = rem_q - 6'(npk);
          stat_d = LINK_BUSY;
        end else if (zpo_q) begin
          zpo_d = 1'b0; pkind_d = KIND_ZLP; stat_d = LINK_BUSY;
        end
      end
      OP_RESET: begin
        stat_d = LINK_UNINIT; pend_d = 7'd0; addr_d = 7'd0; selcfg_d = 8'd0;
        cfgd_d = 1'b0; src_d = SRC_SMALL; off_d = 6'd0; rem_d = 6'd0; zpo_d = 1'b0;
      end
      OP_SUSPEND: begin stat_sv_d = stat_q; stat_d = LINK_SUSPEND; end
      OP_RESUME:  stat_d = stat_sv_q;
      default:    pkind_d = KIND_NONE;
    endcase
  end

  // Sequencer: one result per cycle into the output register while the receiver does not stall
  assign total = (pcnt_q == 4'd0) ? 4'd1 : pcnt_q;
  assign load  = (state_q == ST_EMIT) && (!ov_q || out_ready_i);

  always_comb begin
    state_d = state_q; k_d = k_q;
    ov_d = ov_q && !out_ready_i;
    okind_d = okind_q; odata_d = odata_q; olast_d = olast_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EMIT; k_d = 4'd0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          ov_d = 1'b1;
          okind_d = (pcnt_q == 4'd0) ? pkind_q : KIND_DATA;
          if (pcnt_q == 4'd0) odata_d = 8'd0;
          else if (psrc_q == SRC_SMALL) odata_d = (k_q == 4'd0) ? pb0_q : 8'd0;
          else odata_d = rom_byte(psrc_q, poff_q + 6'(k_q), vid_q, pid_q);
          olast_d = (k_q == total - 4'd1);
          k_d = k_q + 4'd1;
          if (k_q == total - 4'd1) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and function state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ov_q <= 1'b0; k_q <= 4'd0;
      vid_q <= 16'd1684; pid_q <= 16'd65280;
      stat_q <= LINK_UNINIT; stat_sv_q <= LINK_UNINIT; pend_q <= 7'd0; addr_q <= 7'd0;
      selcfg_q <= 8'd0; cfgd_q <= 1'b0; src_q <= SRC_SMALL; off_q <= 6'd0;
      rem_q <= 6'd0; zpo_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d; k_q <= k_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == 1'b0) vid_q <= cfg_data_i;
        else pid_q <= cfg_data_i;
      end
      if (in_fire) begin
        stat_q <= stat_d; stat_sv_q <= stat_sv_d; pend_q <= pend_d; addr_q <= addr_d;
        selcfg_q <= selcfg_d; cfgd_q <= cfgd_d; src_q <= src_d; off_q <= off_d;
        rem_q <= rem_d; zpo_q <= zpo_d;
      end
    end
  end

  // Plan and output payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pkind_q <= pkind_d; pcnt_q <= pcnt_d; psrc_q <= psrc_d; poff_q <= poff_d;
      pb0_q <= pb0_d;
    end
    if (load) begin
      okind_q <= okind_d; odata_q <= odata_d; olast_q <= olast_d;
      oaddr_q <= addr_q; ocfgd_q <= cfgd_q; oselcfg_q <= selcfg_q; ostat_q <= stat_q;
    end
  end

  assign out_valid_o             = ov_q;
  assign kind_o                  = okind_q;
  assign data_byte_o             = odata_q;
  assign last_of_packet_o        = olast_q;
  assign device_address_o        = oaddr_q;
  assign configured_o            = ocfgd_q;
  assign current_configuration_o = oselcfg_q;
  assign link_status_o           = ostat_q;

endmodule

[src/usbreq_checker.sv]
`timescale 1ns / 1ps
module usbreq_checker
  import usbreq_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] data_byte_o,
  input logic       last_of_packet_o
);

  // Held result stays put while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(data_byte_o))
    else $error("stalled result changed");

  // Only data results carry a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> data_byte_o == 8'd0)
    else $error("non-data result carries a byte");

  // Stall, zero-length and idle answers are single results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> last_of_packet_o)
    else $error("single result not marked last");

  // An accepted input blocks the next one: input ready drops after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

endmodule

bind usb_control_request_responder usbreq_checker u_usbreq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .kind_o           (kind_o),
  .data_byte_o      (data_byte_o),
  .last_of_packet_o (last_of_packet_o)
);

[tb/sv/usb_control_request_responder_tb.sv]
`timescale 1ns / 1ps
module usb_control_request_responder_tb;
  import usbreq_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [6:0] addr;
    logic       cfgd;
    logic [7:0] cfg;
    logic [1:0] link;
  } ep0_result_t;

  localparam int MAX_CYCLES = 400000;

  // Scoreboard: endpoint-zero state mirror and queue of expected results
  class ep0_scoreboard;
    logic [15:0] vid, pid;
    logic [1:0]  link_now, link_saved;
    logic [6:0]  addr_pending, addr_active;
    logic [7:0]  cfg_sel;
    logic        cfgd;
    logic [2:0]  src;
    logic [5:0]  offset, remaining;
    logic        zlp_owed;
    ep0_result_t pending_results[$];
    logic [1:0]  kinds[$];
    logic [7:0]  bytes[$];
    int          mismatches;
    int          results_seen;

    function void clear();
      vid = 16'd1684; pid = 16'd65280;
      link_now = LINK_UNINIT; link_saved = LINK_UNINIT;
      addr_pending = '0; addr_active = '0; cfg_sel = '0; cfgd = 1'b0;
      src = '0; offset = '0; remaining = '0; zlp_owed = 1'b0;
      pending_results.delete();
    endfunction

    function logic [7:0] desc_byte(logic [2:0] s, logic [5:0] o);
      logic [7:0] dev [18];
      logic [7:0] cfgd_rom [32];
      logic [7:0] lang [4];
      logic [7:0] s1 [12];
      logic [7:0] s2 [12];
      logic [7:0] q [10];
      dev = '{18, 1, 0, 2, 2, 0, 0, 8, 0, 0, 0, 0, 0, 0, 1, 2, 0, 1};
      cfgd_rom = '{9, 2, 8'h20, 0, 1, 1, 0, 8'hC0, 0, 9, 4, 0, 0, 2, 8'hFF, 8'hFF,
                   8'hFF, 0, 7, 5, 1, 2, 64, 0, 0, 7, 5, 8'h82, 2, 64, 0, 0};
      lang = '{4, 3, 8'h09, 8'h04};
      s1 = '{12, 3, 8'h4C, 0, 8'h45, 0, 8'h47, 0, 8'h4F, 0, 0, 0};
      s2 = '{12, 3, 8'h4E, 0, 8'h78, 0, 8'h4F, 0, 8'h53, 0, 0, 0};
      q = '{10, 6, 0, 2, 2, 0, 0, 8, 1, 0};
      case (s)
        SRC_DEV: begin
          if (o == 8) return vid[7:0];
          if (o == 9) return vid[15:8];
          if (o == 10) return pid[7:0];
          if (o == 11) return pid[15:8];
          return o < 18 ? dev[o] : 8'd0;
        end
        SRC_CFG:  return o < 32 ? cfgd_rom[o] : 8'd0;
        SRC_LANG: return o < 4 ? lang[o] : 8'd0;
        SRC_STR1: return o < 12 ? s1[o] : 8'd0;
        SRC_STR2: return o < 12 ? s2[o] : 8'd0;
        SRC_QUAL: return o < 10 ? q[o] : 8'd0;
        default:  return 8'd0;
      endcase
    endfunction

    function void put(logic [1:0] k, logic [7:0] d);
      if (kinds.size() < 8) begin
        kinds.push_back(k); bytes.push_back(d);
      end
    endfunction

    function void next_packet();
      int n;
      n = remaining > 8 ? 8 : remaining;
      if (n == 0) put(KIND_ZLP, 0);
      for (int i = 0; i < n; i++) put(KIND_DATA, desc_byte(src, 6'(offset + i)));
      offset = 6'(offset + n);
      remaining = 6'(remaining - n);
      link_now = LINK_BUSY;
    endfunction

    function void begin_desc(logic [2:0] s, int size, int wlen);
      src = s; offset = 0;
      remaining = 6'(size < wlen ? size : wlen);
      next_packet();
    endfunction

    function void short_answer(logic [7:0] b0, int size, int wlen);
      int n;
      n = size < wlen ? size : wlen;
      if (n == 0) put(KIND_ZLP, 0);
      if (n >= 1) put(KIND_DATA, b0);
      if (n >= 2) put(KIND_DATA, 0);
      link_now = LINK_BUSY;
    endfunction

    function void zlp_ack();
      put(KIND_ZLP, 0);
      link_now = LINK_BUSY;
    endfunction

    function void handle_setup(logic [7:0] rt, logic [7:0] code, logic [15:0] val, int wlen);
      logic [7:0] idx;
      idx = val[7:0];
      src = 0; offset = 0; remaining = 0; zlp_owed = 0;
      case (code) inside
        REQ_GET_STATUS: short_answer(rt[3:0] == 0 ? 8'd1 : 8'd0, 2, wlen);
        REQ_CLR_FEAT, REQ_SET_FEAT, REQ_SET_IFACE: zlp_ack();
        REQ_SET_ADDR: begin
          addr_pending = val[6:0];
          zlp_ack();
          if (addr_pending == 0) begin
            addr_active = 0; cfgd = 0;
          end
        end
        REQ_GET_DESC: begin
          case (val[15:8])
            DESC_DEVICE: begin_desc(SRC_DEV, 18, wlen);
            DESC_CONFIG: begin
              begin_desc(SRC_CFG, 32, wlen);
              if (wlen > 32) zlp_owed = 1;
            end
            DESC_STRING: begin
              if (idx == 0) begin_desc(SRC_LANG, 4, wlen);
              else if (idx == 1) begin_desc(SRC_STR1, 12, wlen);
              else if (idx == 2) begin_desc(SRC_STR2, 12, wlen);
              else put(KIND_STALL, 0);
            end
            DESC_QUAL: begin_desc(SRC_QUAL, 10, wlen);
            default: put(KIND_STALL, 0);
          endcase
        end
        REQ_GET_CFG: short_answer(cfg_sel, 1, wlen);
        REQ_SET_CFG: begin
          cfg_sel = idx; cfgd = idx != 0; zlp_ack();
        end
        default: put(KIND_STALL, 0);
      endcase
    endfunction

    // Accepted input: update the mirror and queue what the block must send
    function void note_request(logic [2:0] op, logic [7:0] rt, logic [7:0] code,
                               logic [15:0] val, logic [15:0] wlen);
      ep0_result_t r;
      kinds.delete(); bytes.delete();
      case (op)
        OP_SETUP: handle_setup(rt, code, val, wlen);
        OP_IN_ACK: begin
          link_now = LINK_READY;
          if (addr_pending != 0) begin
            addr_active = addr_pending; addr_pending = 0; cfgd = 0;
          end
          if (remaining > 0) next_packet();
          else if (zlp_owed) begin
            zlp_owed = 0; zlp_ack();
          end
        end
        OP_RESET: begin
          link_now = LINK_UNINIT; addr_pending = 0; addr_active = 0; cfg_sel = 0;
          cfgd = 0; src = 0; offset = 0; remaining = 0; zlp_owed = 0;
        end
        OP_SUSPEND: begin
          link_saved = link_now; link_now = LINK_SUSPEND;
        end
        OP_RESUME: link_now = link_saved;
        default: ;
      endcase
      if (kinds.size() == 0) put(KIND_NONE, 0);
      foreach (kinds[k]) begin
        r.kind = kinds[k];
        r.data = kinds[k] == KIND_DATA ? bytes[k] : 8'd0;
        r.last = k == kinds.size() - 1;
        r.addr = addr_active; r.cfgd = cfgd; r.cfg = cfg_sel; r.link = link_now;
        pending_results.push_back(r);
      end
    endfunction

    task check_result(ep0_result_t got);
      ep0_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result %p", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind != want.kind) report_error($sformatf("kind %0d want %0d", got.kind, want.kind));
      if (got.data != want.data) report_error($sformatf("byte %h want %h", got.data, want.data));
      if (got.last != want.last) report_error($sformatf("last %0d want %0d", got.last, want.last));
      if (got.addr != want.addr) report_error($sformatf("addr %0d want %0d", got.addr, want.addr));
      if (got.cfgd != want.cfgd) report_error($sformatf("configured %0d want %0d",
                                                         got.cfgd, want.cfgd));
      if (got.cfg != want.cfg) report_error($sformatf("config %0d want %0d", got.cfg, want.cfg));
      if (got.link != want.link) report_error($sformatf("link %0d want %0d", got.link, want.link));
    endtask

    task report_error(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_i = '0;
  logic [7:0]  request_type_i = '0;
  logic [7:0]  request_code_i = '0;
  logic [15:0] request_value_i = '0;
  logic [15:0] request_index_i = '0;
  logic [15:0] request_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic        last_of_packet_o;
  logic [6:0]  device_address_o;
  logic        configured_o;
  logic [7:0]  current_configuration_o;
  logic [1:0]  link_status_o;

  ep0_scoreboard sb = new();
  int  cycle_count = 0;
  bit  idle_enable = 1'b1;
  int  requests_sent = 0;

  always #5 clk_i = ~clk_i;

  usb_control_request_responder DUT (.*);

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("usb_control_request_responder_tb: errors");
      $finish;
    end
  end

  // Receiver: random stall bursts, result check on each transfer
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_result('{kind_o, data_byte_o, last_of_packet_o, device_address_o,
                          configured_o, current_configuration_o, link_status_o});
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 9);
        out_ready_i <= 1'b0;
      end else out_ready_i <= 1'b1;
    end
  end

  // Valid stays up between back-to-back transfers; it drops for idle gaps, id writes and the end of the run
  task automatic send_request(logic [2:0] op, logic [7:0] rt, logic [7:0] code,
                              logic [15:0] val, logic [15:0] wlen);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op; request_type_i <= rt; request_code_i <= code;
    request_value_i <= val; request_index_i <= 16'($urandom);
    request_length_i <= wlen;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, rt, code, val, wlen);
    requests_sent++;
  endtask

  task automatic write_id(logic idx, logic [15:0] val);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx) sb.pid = val;
    else sb.vid = val;
  endtask

  // Mostly well-formed control transfers with random lengths
  task automatic random_request();
    logic [15:0] wlen;
    logic [7:0]  code;
    logic [15:0] val;
    int pick;
    int codes [8] = '{0, 1, 3, 5, 6, 8, 9, 11};
    pick = $urandom_range(0, 99);
    wlen = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
    code = 8'(codes[$urandom_range(0, 7)]);
    val = 16'($urandom);
    if (code == REQ_GET_DESC && $urandom_range(0, 4) != 0)
      val = {8'(($urandom_range(0, 3) == 3) ? 6 : $urandom_range(1, 3)),
             8'($urandom_range(0, 3))};
    if (pick < 45) send_request(OP_SETUP, 8'($urandom), code, val, wlen);
    else if (pick < 80) send_request(OP_IN_ACK, 0, 0, 0, 0);
    else if (pick < 85) send_request(OP_SETUP, 8'($urandom), 8'($urandom), val, wlen);
    else if (pick < 89) send_request(OP_RESET, 0, 0, 0, 0);
    else if (pick < 93) send_request(OP_SUSPEND, 0, 0, 0, 0);
    else if (pick < 97) send_request(OP_RESUME, 0, 0, 0, 0);
    else send_request(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom), val, wlen);
  endtask

  initial begin
    sb.clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: descriptor, status, address and configuration requests, and every bus event
    write_id(1'b0, 16'hFFFF);
    write_id(1'b1, 16'h0000);
    send_request(OP_SETUP, 8'h80, REQ_GET_DESC, 16'h0100, 16'hFFFF);
    repeat (3) send_request(OP_IN_ACK, 0, 0, 0, 0);
    send_request(OP_SETUP, 8'h80, REQ_GET_DESC, 16'h0200, 16'd64);
    repeat (5) send_request(OP_IN_ACK, 0, 0, 0, 0);
    send_request(OP_SETUP, 8'h80, REQ_GET_DESC, 16'h0302, 16'd0);
    send_request(OP_SETUP, 8'h80, REQ_GET_DESC, 16'h0303, 16'd9);
    send_request(OP_SETUP, 8'h80, REQ_GET_DESC, 16'h0600, 16'd10);
    send_request(OP_SETUP, 8'h80, REQ_GET_DESC, 16'h0700, 16'd10);
    send_request(OP_SETUP, 8'h81, REQ_GET_STATUS, 0, 16'd1);
    send_request(OP_SETUP, 8'h00, REQ_SET_ADDR, 16'hFFFF, 0);
    send_request(OP_IN_ACK, 0, 0, 0, 0);
    send_request(OP_SETUP, 8'h00, REQ_SET_CFG, 16'h00FF, 0);
    send_request(OP_SETUP, 8'h80, REQ_GET_CFG, 0, 16'd5);
    send_request(OP_SETUP, 8'h00, REQ_SET_ADDR, 16'h0080, 0);
    send_request(OP_SUSPEND, 0, 0, 0, 0);
    send_request(OP_SUSPEND, 0, 0, 0, 0);
    send_request(OP_RESUME, 0, 0, 0, 0);
    send_request(OP_RESET, 0, 0, 0, 0);
    send_request(3'd7, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);

    for (int i = 0; i < 400; i++) begin
      if (i % 100 == 50) write_id(1'(i / 100 % 2), 16'($urandom));
      if (i == 320) idle_enable = 1'b0;
      random_request();
    end
    write_id(1'b0, 16'h0000);
    write_id(1'b1, 16'hFFFF);
    send_request(OP_SETUP, 8'h80, REQ_GET_DESC, 16'h0100, 16'd18);
    repeat (2) send_request(OP_IN_ACK, 0, 0, 0, 0);

    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d requests and events sent, %0d results checked across id settings",
             requests_sent, sb.results_seen);
    if (sb.mismatches == 0) $display("usb_control_request_responder_tb: clean");
    else $display("usb_control_request_responder_tb: errors");
    $finish;
  end

endmodule
